// ===== rtl/grt_pkg.sv =====
// grt_pkg: shared types and constants of the grid ray traversal block
// used by grt_div, grt_mul and grid_ray_traversal_solid_hit

package grt_pkg;

   // divider: 50-bit dividend (up to a 34-bit numerator shifted by 16), 23-bit divisor
   localparam int DIV_W  = 50;
   localparam int DIV_DV = 23;
   localparam int DIV_CW = 6;

   // multiplier: 33-bit by 24-bit signed
   localparam int MUL_AW = 33;
   localparam int MUL_BW = 24;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   localparam logic [31:0] T_INF   = 32'h8000_0000;
   localparam logic [22:0] TS_MIN  = 23'd65536;

   // configuration register indexes
   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TILE_SIZE  = 2'd2;

   // request codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CAST  = 1'b1;

   // surface normal codes
   localparam logic [2:0] NRM_NONE = 3'd0;
   localparam logic [2:0] NRM_NEGX = 3'd1;
   localparam logic [2:0] NRM_POSX = 3'd2;
   localparam logic [2:0] NRM_NEGY = 3'd3;
   localparam logic [2:0] NRM_POSY = 3'd4;
   localparam logic [2:0] NRM_REV  = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CX,
      S_CY,
      S_DIV,
      S_LOOK,
      S_START,
      S_TDX,
      S_TDY,
      S_BX,
      S_BXD,
      S_BY,
      S_BYD,
      S_STEP,
      S_WAIT,
      S_TEST,
      S_HX,
      S_HXD,
      S_HYD,
      S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_CX,
      OP_CY,
      OP_TDX,
      OP_TDY,
      OP_TMX,
      OP_TMY
   } div_op_type;

   // clamp a quotient to the "infinite" boundary time
   function automatic logic [31:0] sat_t(input logic [DIV_W-1:0] q);
      logic big;
      big = (|q[DIV_W-1:32]) || (q[31:0] > T_INF);
      return big ? T_INF : q[31:0];
   endfunction

   // s + floor(p / 2^16), p a signed product
   function automatic logic signed [41:0] along(input logic signed [31:0] s,
                                                input logic signed [MUL_PW-1:0] p);
      logic signed [41:0] se;
      logic signed [41:0] pe;
      se = {{10{s[31]}}, s};
      pe = {p[MUL_PW-1], p[MUL_PW-1:16]};
      return se + pe;
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [41:0] v);
      logic [31:0] r;
      if ((&v[41:31]) || !(|v[41:31])) begin
         r = v[31:0];
      end else if (v[41]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7fff_ffff;
      end
      return r;
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [17:0] abs18(input logic signed [17:0] v);
      return v[17] ? (~v + 18'd1) : v;
   endfunction

endpackage

// ===== rtl/grt_div.sv =====
// grt_div: unsigned restoring divider, one quotient bit per cycle
// depends on grt_pkg for its widths

module grt_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [grt_pkg::DIV_W-1:0]      dividend,
   input  logic [grt_pkg::DIV_DV-1:0]     divisor,
   output logic                           done,
   output logic [grt_pkg::DIV_W-1:0]      quotient,
   output logic [grt_pkg::DIV_DV-1:0]     remainder
);

   logic [grt_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [grt_pkg::DIV_DV-1:0] rem_ff, rem_in;
   logic [grt_pkg::DIV_DV-1:0] dvs_ff, dvs_in;
   logic [grt_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [grt_pkg::DIV_DV:0]   shifted;
   logic [grt_pkg::DIV_DV+1:0] trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[grt_pkg::DIV_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = grt_pkg::DIV_CW'(grt_pkg::DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[grt_pkg::DIV_DV+1]) begin
            rem_in = trial[grt_pkg::DIV_DV-1:0];
            quo_in = {quo_ff[grt_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[grt_pkg::DIV_DV-1:0];
            quo_in = {quo_ff[grt_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == grt_pkg::DIV_CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/grt_mul.sv =====
// grt_mul: shared signed multiplier with a registered product
// depends on grt_pkg for its widths

module grt_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [grt_pkg::MUL_AW-1:0]   a,
   input  logic signed [grt_pkg::MUL_BW-1:0]   b,
   output logic signed [grt_pkg::MUL_PW-1:0]   prod
);

   logic signed [grt_pkg::MUL_PW-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (en) begin
         prod_in = grt_pkg::MUL_PW'(a) * grt_pkg::MUL_PW'(b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/grt_map.sv =====
// grt_map: one-bit solid tile memory with a clearing sweep after reset
// no package dependencies

module grt_map #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   output logic          busy
);

   logic          mem [DEPTH];
   logic          rd_ff;
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
   assign busy    = clr_ff;

endmodule

// ===== rtl/grid_ray_traversal_solid_hit.sv =====
// grid_ray_traversal_solid_hit: top level of the tile grid ray caster
// uses grt_pkg, grt_div, grt_mul and grt_map

// A write item (func 0) sets or clears one tile's solid bit. A cast item
// (func 1) walks a ray through the tile grid and returns one result item:
// the first solid in-bounds tile entered where the ray's z lies within
// [0, tile_size] (tile_size raised to at least 65536), or an all-zero miss.
// Steps of a cast: the start tile takes two passes of the shared divider,
// then the per-axis crossing times take up to four more (fewer for a zero
// direction component), then each tile crossing uses the shared multiplier
// for z plus the registered map read, and a hit then computes the impact
// point. A long ray over small tiles may cross tens of thousands of tiles.
// The block takes one item at a time; a finished result waits in the output
// register while the next item is accepted. After reset the map clears its
// MAX_COLS*MAX_ROWS tiles one tile per cycle, during which no item is taken;
// configuration writes are taken at any time.

module grid_ray_traversal_solid_hit #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [5:0]         req_tile_col,
   input  logic [5:0]         req_tile_row,
   input  logic               req_solid_bit,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [17:0] req_dir_x,
   input  logic signed [17:0] req_dir_y,
   input  logic signed [17:0] req_dir_z,
   input  logic [30:0]        req_max_dist,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [30:0]        rsp_impact_dist,
   output logic signed [31:0] rsp_impact_x,
   output logic signed [31:0] rsp_impact_y,
   output logic signed [31:0] rsp_impact_z,
   output logic [2:0]         rsp_normal_code,
   // configuration
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [22:0]        csr_wdata
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [16:0] COLS_LIM = 17'(MAX_COLS);
   localparam logic [16:0] ROWS_LIM = 17'(MAX_ROWS);

   // configuration registers
   logic [6:0]  map_width_ff, map_height_ff;
   logic [22:0] tile_size_ff;
   logic [22:0] ts_eff;

   // sequencer
   grt_pkg::state_type  state_ff, state_in;
   grt_pkg::div_op_type div_op_ff, div_op_in;

   // latched cast item
   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic signed [17:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [30:0]        dist_ff, dist_in;

   // walk state
   logic signed [17:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]        tdx_ff, tdx_in, tdy_ff, tdy_in;
   logic [31:0]        tmx_ff, tmx_in, tmy_ff, tmy_in;
   logic [31:0]        t_cur_ff, t_cur_in;
   logic               axis_x_ff, axis_x_in;

   // staged result
   logic        res_hit_ff, res_hit_in;
   logic [30:0] res_t_ff, res_t_in;
   logic [31:0] res_x_ff, res_x_in, res_y_ff, res_y_in, res_z_ff, res_z_in;
   logic [2:0]  res_code_ff, res_code_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [30:0] rsp_t_ff, rsp_t_in;
   logic [31:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [2:0]  rsp_code_ff, rsp_code_in;

   // shared units
   logic                              div_start;
   logic [grt_pkg::DIV_W-1:0]         div_dividend;
   logic [grt_pkg::DIV_DV-1:0]        div_divisor;
   logic                              div_done;
   logic [grt_pkg::DIV_W-1:0]         div_q;
   logic [grt_pkg::DIV_DV-1:0]        div_r;
   logic                              mul_en;
   logic signed [grt_pkg::MUL_AW-1:0] mul_a;
   logic signed [grt_pkg::MUL_BW-1:0] mul_b;
   logic signed [grt_pkg::MUL_PW-1:0] mul_p;

   // map
   logic          map_wr_en;
   logic [AW-1:0] map_wr_addr;
   logic [AW-1:0] map_rd_addr;
   logic          map_rd_data;
   logic          map_busy;

   // helpers
   logic               req_accept;
   logic               rsp_load;
   logic               dx_pos, dy_pos;
   logic [17:0]        adx, ady;
   logic [16:0]        w_lim, h_lim;
   logic               in_bounds;
   logic               solid;
   logic signed [18:0] cx_inc, cy_inc;
   logic signed [41:0] bdiff;
   logic [41:0]        babs;
   logic signed [41:0] zs;
   logic               z_ok;
   logic               x_first;
   logic [32:0]        tm_sum;
   logic [17:0]        tile_q;

   assign ts_eff = (tile_size_ff < grt_pkg::TS_MIN) ? grt_pkg::TS_MIN : tile_size_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 7'd64;
         map_height_ff <= 7'd64;
         tile_size_ff  <= 23'd65536;
      end else if (csr_write_en) begin
         unique case (csr_index)
            grt_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata[6:0];
            grt_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata[6:0];
            grt_pkg::CSR_TILE_SIZE:  tile_size_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall  = (state_ff != grt_pkg::S_IDLE) || map_busy;
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == grt_pkg::S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign dx_pos = !dx_ff[17] && (dx_ff != '0);
   assign dy_pos = !dy_ff[17] && (dy_ff != '0);
   assign adx    = grt_pkg::abs18(dx_ff);
   assign ady    = grt_pkg::abs18(dy_ff);

   // map bounds, clamped to storage
   assign w_lim = ({10'd0, map_width_ff} > COLS_LIM) ? COLS_LIM : {10'd0, map_width_ff};
   assign h_lim = ({10'd0, map_height_ff} > ROWS_LIM) ? ROWS_LIM : {10'd0, map_height_ff};
   assign in_bounds = !cx_ff[17] && (cx_ff[16:0] < w_lim) &&
                      !cy_ff[17] && (cy_ff[16:0] < h_lim);
   assign map_rd_addr = in_bounds ?
      AW'(32'(cy_ff[16:0]) * 32'(MAX_COLS) + 32'(cx_ff[16:0])) : '0;
   // tile address is presented the cycle before the registered read is used
   assign solid = in_bounds && map_rd_data;

   // writes outside storage are dropped
   assign map_wr_en = req_accept && (req_func == grt_pkg::FUNC_WRITE) &&
                      (32'(req_tile_col) < 32'(MAX_COLS)) &&
                      (32'(req_tile_row) < 32'(MAX_ROWS));
   assign map_wr_addr = AW'(32'(req_tile_row) * 32'(MAX_COLS) + 32'(req_tile_col));

   assign cx_inc = {cx_ff[17], cx_ff} + (dx_pos ? 19'sd1 : 19'sd0);
   assign cy_inc = {cy_ff[17], cy_ff} + (dy_pos ? 19'sd1 : 19'sd0);

   // distance from start to first boundary, product holds the boundary
   assign bdiff = $signed(mul_p[41:0]) -
                  $signed({{10{(state_ff == grt_pkg::S_BXD) ? sx_ff[31] : sy_ff[31]}},
                           (state_ff == grt_pkg::S_BXD) ? sx_ff : sy_ff});
   assign babs  = bdiff[41] ? (~bdiff + 42'd1) : bdiff;

   // z along the ray at the tile entry
   assign zs   = grt_pkg::along(sz_ff, mul_p);
   assign z_ok = !zs[41] && (zs <= $signed({19'd0, ts_eff}));

   assign x_first = tmx_ff < tmy_ff;
   assign tm_sum  = axis_x_ff ? ({1'b0, tmx_ff} + {1'b0, tdx_ff})
                              : ({1'b0, tmy_ff} + {1'b0, tdy_ff});

   // floor of a signed coordinate over the tile size from |coord| / ts
   assign tile_q = (div_op_ff == grt_pkg::OP_CX ? sx_ff[31] : sy_ff[31]) ?
                   (~(div_q[17:0] + {17'd0, div_r != '0}) + 18'd1) : div_q[17:0];

   // shared multiplier operands
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         grt_pkg::S_BX: begin
            mul_en = 1'b1;
            mul_a  = {{14{cx_inc[18]}}, cx_inc};
            mul_b  = {1'b0, ts_eff};
         end
         grt_pkg::S_BY: begin
            mul_en = 1'b1;
            mul_a  = {{14{cy_inc[18]}}, cy_inc};
            mul_b  = {1'b0, ts_eff};
         end
         grt_pkg::S_STEP: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, x_first ? tmx_ff : tmy_ff};
            mul_b  = {{6{dz_ff[17]}}, dz_ff};
         end
         grt_pkg::S_HX: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, t_cur_ff};
            mul_b  = {{6{dx_ff[17]}}, dx_ff};
         end
         grt_pkg::S_HXD: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, t_cur_ff};
            mul_b  = {{6{dy_ff[17]}}, dy_ff};
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      div_op_in    = div_op_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sz_in        = sz_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      dist_in      = dist_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      tdx_in       = tdx_ff;
      tdy_in       = tdy_ff;
      tmx_in       = tmx_ff;
      tmy_in       = tmy_ff;
      t_cur_in     = t_cur_ff;
      axis_x_in    = axis_x_ff;
      res_hit_in   = res_hit_ff;
      res_t_in     = res_t_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_z_in     = res_z_ff;
      res_code_in  = res_code_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = ts_eff;

      unique case (state_ff)
         grt_pkg::S_IDLE: begin
            if (req_accept && (req_func == grt_pkg::FUNC_CAST)) begin
               sx_in    = req_start_x;
               sy_in    = req_start_y;
               sz_in    = req_start_z;
               dx_in    = req_dir_x;
               dy_in    = req_dir_y;
               dz_in    = req_dir_z;
               dist_in  = req_max_dist;
               state_in = grt_pkg::S_CX;
            end
         end
         grt_pkg::S_CX: begin
            div_start    = 1'b1;
            div_dividend = {18'd0, grt_pkg::abs32(sx_ff)};
            div_divisor  = ts_eff;
            div_op_in    = grt_pkg::OP_CX;
            state_in     = grt_pkg::S_DIV;
         end
         grt_pkg::S_CY: begin
            div_start    = 1'b1;
            div_dividend = {18'd0, grt_pkg::abs32(sy_ff)};
            div_divisor  = ts_eff;
            div_op_in    = grt_pkg::OP_CY;
            state_in     = grt_pkg::S_DIV;
         end
         grt_pkg::S_DIV: begin
            if (div_done) begin
               unique case (div_op_ff)
                  grt_pkg::OP_CX: begin
                     cx_in    = tile_q;
                     state_in = grt_pkg::S_CY;
                  end
                  grt_pkg::OP_CY: begin
                     cy_in    = tile_q;
                     state_in = grt_pkg::S_LOOK;
                  end
                  grt_pkg::OP_TDX: begin
                     tdx_in   = grt_pkg::sat_t(div_q);
                     state_in = grt_pkg::S_TDY;
                  end
                  grt_pkg::OP_TDY: begin
                     tdy_in   = grt_pkg::sat_t(div_q);
                     state_in = grt_pkg::S_BX;
                  end
                  grt_pkg::OP_TMX: begin
                     tmx_in   = grt_pkg::sat_t(div_q);
                     state_in = grt_pkg::S_BY;
                  end
                  grt_pkg::OP_TMY: begin
                     tmy_in   = grt_pkg::sat_t(div_q);
                     state_in = grt_pkg::S_STEP;
                  end
                  default: state_in = grt_pkg::S_IDLE;
               endcase
            end
         end
         grt_pkg::S_LOOK: begin
            // map read of the start tile lands at the end of this cycle
            state_in = grt_pkg::S_START;
         end
         grt_pkg::S_START: begin
            if (solid && !sz_ff[31] && ($signed(sz_ff) <= $signed({9'd0, ts_eff}))) begin
               res_hit_in  = 1'b1;
               res_t_in    = '0;
               res_x_in    = sx_ff;
               res_y_in    = sy_ff;
               res_z_in    = sz_ff;
               res_code_in = grt_pkg::NRM_REV;
               state_in    = grt_pkg::S_EMIT;
            end else begin
               state_in = grt_pkg::S_TDX;
            end
         end
         grt_pkg::S_TDX: begin
            if (dx_ff == '0) begin
               tdx_in   = grt_pkg::T_INF;
               state_in = grt_pkg::S_TDY;
            end else begin
               div_start    = 1'b1;
               div_dividend = {11'd0, ts_eff, 16'd0};
               div_divisor  = {5'd0, adx};
               div_op_in    = grt_pkg::OP_TDX;
               state_in     = grt_pkg::S_DIV;
            end
         end
         grt_pkg::S_TDY: begin
            if (dy_ff == '0) begin
               tdy_in   = grt_pkg::T_INF;
               state_in = grt_pkg::S_BX;
            end else begin
               div_start    = 1'b1;
               div_dividend = {11'd0, ts_eff, 16'd0};
               div_divisor  = {5'd0, ady};
               div_op_in    = grt_pkg::OP_TDY;
               state_in     = grt_pkg::S_DIV;
            end
         end
         grt_pkg::S_BX: begin
            if (dx_ff == '0) begin
               tmx_in   = grt_pkg::T_INF;
               state_in = grt_pkg::S_BY;
            end else begin
               state_in = grt_pkg::S_BXD;
            end
         end
         grt_pkg::S_BXD: begin
            div_start    = 1'b1;
            div_dividend = {babs[33:0], 16'd0};
            div_divisor  = {5'd0, adx};
            div_op_in    = grt_pkg::OP_TMX;
            state_in     = grt_pkg::S_DIV;
         end
         grt_pkg::S_BY: begin
            if (dy_ff == '0) begin
               tmy_in   = grt_pkg::T_INF;
               state_in = grt_pkg::S_STEP;
            end else begin
               state_in = grt_pkg::S_BYD;
            end
         end
         grt_pkg::S_BYD: begin
            div_start    = 1'b1;
            div_dividend = {babs[33:0], 16'd0};
            div_divisor  = {5'd0, ady};
            div_op_in    = grt_pkg::OP_TMY;
            state_in     = grt_pkg::S_DIV;
         end
         grt_pkg::S_STEP: begin
            // x on strictly nearer boundary, ties go to y
            if (x_first) begin
               if (tmx_ff > {1'b0, dist_ff}) begin
                  res_hit_in  = 1'b0;
                  res_t_in    = '0;
                  res_x_in    = '0;
                  res_y_in    = '0;
                  res_z_in    = '0;
                  res_code_in = grt_pkg::NRM_NONE;
                  state_in    = grt_pkg::S_EMIT;
               end else begin
                  cx_in     = cx_ff + (dx_pos ? 18'sd1 : -18'sd1);
                  t_cur_in  = tmx_ff;
                  axis_x_in = 1'b1;
                  state_in  = grt_pkg::S_WAIT;
               end
            end else begin
               if (tmy_ff > {1'b0, dist_ff}) begin
                  res_hit_in  = 1'b0;
                  res_t_in    = '0;
                  res_x_in    = '0;
                  res_y_in    = '0;
                  res_z_in    = '0;
                  res_code_in = grt_pkg::NRM_NONE;
                  state_in    = grt_pkg::S_EMIT;
               end else begin
                  cy_in     = cy_ff + (dy_pos ? 18'sd1 : -18'sd1);
                  t_cur_in  = tmy_ff;
                  axis_x_in = 1'b0;
                  state_in  = grt_pkg::S_WAIT;
               end
            end
         end
         grt_pkg::S_WAIT: begin
            state_in = grt_pkg::S_TEST;
         end
         grt_pkg::S_TEST: begin
            if (solid && z_ok) begin
               res_hit_in  = 1'b1;
               res_t_in    = t_cur_ff[30:0];
               res_z_in    = grt_pkg::sat32(zs);
               if (axis_x_ff) begin
                  res_code_in = dx_pos ? grt_pkg::NRM_NEGX : grt_pkg::NRM_POSX;
               end else begin
                  res_code_in = dy_pos ? grt_pkg::NRM_NEGY : grt_pkg::NRM_POSY;
               end
               state_in = grt_pkg::S_HX;
            end else begin
               if (axis_x_ff) begin
                  tmx_in = (tm_sum > {1'b0, grt_pkg::T_INF}) ? grt_pkg::T_INF : tm_sum[31:0];
               end else begin
                  tmy_in = (tm_sum > {1'b0, grt_pkg::T_INF}) ? grt_pkg::T_INF : tm_sum[31:0];
               end
               state_in = grt_pkg::S_STEP;
            end
         end
         grt_pkg::S_HX: begin
            state_in = grt_pkg::S_HXD;
         end
         grt_pkg::S_HXD: begin
            res_x_in = grt_pkg::sat32(grt_pkg::along(sx_ff, mul_p));
            state_in = grt_pkg::S_HYD;
         end
         grt_pkg::S_HYD: begin
            res_y_in = grt_pkg::sat32(grt_pkg::along(sy_ff, mul_p));
            state_in = grt_pkg::S_EMIT;
         end
         grt_pkg::S_EMIT: begin
            if (rsp_load) begin
               state_in = grt_pkg::S_IDLE;
            end
         end
         default: state_in = grt_pkg::S_IDLE;
      endcase
   end

   // output register, free again once the item is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_t_in     = rsp_t_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_code_in  = rsp_code_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = res_hit_ff;
         rsp_t_in     = res_t_ff;
         rsp_x_in     = res_x_ff;
         rsp_y_in     = res_y_ff;
         rsp_z_in     = res_z_ff;
         rsp_code_in  = res_code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grt_pkg::S_IDLE;
         div_op_ff    <= grt_pkg::OP_CX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_op_ff    <= div_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      dist_ff     <= dist_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      tdx_ff      <= tdx_in;
      tdy_ff      <= tdy_in;
      tmx_ff      <= tmx_in;
      tmy_ff      <= tmy_in;
      t_cur_ff    <= t_cur_in;
      axis_x_ff   <= axis_x_in;
      res_hit_ff  <= res_hit_in;
      res_t_ff    <= res_t_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_z_ff    <= res_z_in;
      res_code_ff <= res_code_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_t_ff    <= rsp_t_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_impact_dist = rsp_t_ff;
   assign rsp_impact_x    = rsp_x_ff;
   assign rsp_impact_y    = rsp_y_ff;
   assign rsp_impact_z    = rsp_z_ff;
   assign rsp_normal_code = rsp_code_ff;

   grt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   grt_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_p)
   );

   grt_map #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (req_solid_bit),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .busy    (map_busy)
   );

endmodule
